@@ src/bus_bridge_response_parser_macros.svh @@
// assertion macros for the bus bridge response parser
`ifndef BUS_BRIDGE_RESPONSE_PARSER_MACROS_SVH
`define BUS_BRIDGE_RESPONSE_PARSER_MACROS_SVH

// condition must hold on every clock edge outside reset
`define BBRP_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger implies consequence on the next clock edge
`define BBRP_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bbrp_pkg.sv @@
// types, codes and helpers shared by the bus bridge response parser
`default_nettype none
package bbrp_pkg;

   localparam logic [1:0] OP_ISSUE   = 2'd0;
   localparam logic [1:0] OP_RX      = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   localparam logic [2:0] K_DONE  = 3'd0;
   localparam logic [2:0] K_INTR  = 3'd1;
   localparam logic [2:0] K_UNEXP = 3'd2;
   localparam logic [2:0] K_UNREC = 3'd3;
   localparam logic [2:0] K_INV   = 3'd4;
   localparam logic [2:0] K_ERR   = 3'd5;
   localparam logic [2:0] K_BUSY  = 3'd6;

   localparam logic [2:0] S_OK      = 3'd0;
   localparam logic [2:0] S_ACK     = 3'd1;
   localparam logic [2:0] S_NOACK   = 3'd2;
   localparam logic [2:0] S_TIMEOUT = 3'd3;
   localparam logic [2:0] S_SYNTAX  = 3'd4;
   localparam logic [2:0] S_RESPERR = 3'd5;

   localparam logic [1:0] RT_NONE  = 2'd0;
   localparam logic [1:0] RT_VALUE = 2'd1;
   localparam logic [1:0] RT_CAPS  = 2'd2;
   localparam logic [1:0] RT_MULTI = 2'd3;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_UC    = 8'h43;
   localparam logic [7:0] CH_UD    = 8'h44;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UI    = 8'h49;
   localparam logic [7:0] CH_UM    = 8'h4D;
   localparam logic [7:0] CH_UR    = 8'h52;
   localparam logic [7:0] CH_US    = 8'h53;
   localparam logic [7:0] CH_UT    = 8'h54;
   localparam logic [7:0] CH_UU    = 8'h55;
   localparam logic [7:0] CH_UV    = 8'h56;
   localparam logic [7:0] CH_UW    = 8'h57;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LI    = 8'h69;
   localparam logic [7:0] CH_LM    = 8'h6D;
   localparam logic [7:0] CH_LR    = 8'h72;
   localparam logic [7:0] CH_LU    = 8'h75;
   localparam logic [7:0] CH_LW    = 8'h77;

   typedef enum logic [3:0] {
      PH_START, PH_G_CODE, PH_G_A, PH_G_BSTART, PH_G_B, PH_G_SKIP,
      PH_MR_HEX, PH_MR_VAL, PH_MR_U, PH_MR_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_READ, ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] request_code;
      logic [5:0] read_count;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  status;
      logic [1:0]  ret_form;
      logic [15:0] value;
      logic [15:0] extra_value;
      logic [5:0]  value_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic rd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic drain;
      logic drain_last;
   } stat_type;

   // valid flag then digit
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/bbrp_ctrl.sv @@
// controller: request acceptance and multi-read drain sequencing
`default_nettype none
module bbrp_ctrl
   import bbrp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !stat.out_free;
            cmd.take = req_valid && stat.out_free;
            if (cmd.take && stat.drain) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.drain_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ src/bbrp_datapath.sv @@
// datapath: line parser registers, read value memory and result register
`default_nettype none
module bbrp_datapath
   import bbrp_pkg::*;
#(
   parameter int MAX_READS = 32
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire logic    rsp_stall,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_READS + 1);
   localparam int IDX_W = (MAX_READS > 1) ? $clog2(MAX_READS) : 1;

   logic             pend_ff, pend_in;
   logic [7:0]       pc_ff, pc_in;
   logic [CNT_W-1:0] er_ff, er_in;
   phase_type        ph_ff, ph_in;
   logic [7:0]       lc_ff, lc_in;
   logic [15:0]      fa_ff, fa_in;
   logic [15:0]      fb_ff, fb_in;
   logic [1:0]       fc_ff, fc_in;
   logic [2:0]       le_ff, le_in;
   logic [CNT_W-1:0] vp_ff, vp_in;
   logic [CNT_W-1:0] idx_ff;
   logic [15:0]      rd_data_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic [15:0]      mem [MAX_READS];

   logic       we;
   logic       r_single, r_drain;
   rsp_type    r;
   logic       do_gen, do_multi, do_mr, hv;
   logic [3:0] hd;
   logic [7:0] b;
   logic [2:0] gst, okst;
   logic [7:0] exp_req, cur;
   logic [1:0] exp_n;

   assign b = req_data.rx_byte;
   assign {hv, hd} = hex_decode(req_data.rx_byte);

   always_comb begin
      pend_in = pend_ff; pc_in = pc_ff; er_in = er_ff; ph_in = ph_ff;
      lc_in = lc_ff; fa_in = fa_ff; fb_in = fb_ff; fc_in = fc_ff;
      le_in = le_ff; vp_in = vp_ff;
      we = 1'b0; r_single = 1'b0; r_drain = 1'b0; r = '0; r.last = 1'b1;
      do_gen = 1'b0; do_multi = 1'b0; do_mr = 1'b0;
      gst = K_DONE; okst = S_OK; exp_req = 8'd0; exp_n = 2'd0;
      cur = 8'd0;
      unique case (req_data.opcode)
         OP_ISSUE: begin
            if (pend_ff) begin
               r_single = 1'b1; r.kind = K_BUSY;
            end else if (req_data.request_code == CH_UT) begin
               r_single = 1'b1; r.kind = K_DONE;
            end else begin
               pend_in = 1'b1;
               pc_in = req_data.request_code;
               if (int'(req_data.read_count) > MAX_READS) er_in = CNT_W'(MAX_READS);
               else er_in = CNT_W'(req_data.read_count);
            end
         end
         OP_TIMEOUT: begin
            if (pend_ff) begin
               pend_in = 1'b0; r_single = 1'b1; r.status = S_TIMEOUT;
            end
         end
         OP_RX: begin
            unique case (ph_ff)
               PH_START: begin
                  lc_in = b; fa_in = '0; fb_in = '0; fc_in = '0; le_in = '0; vp_in = '0;
                  if (b == CH_NL) do_gen = 1'b1;
                  else if ((b == CH_UM || b == CH_LM) && pend_ff && pc_ff == CH_UM)
                     do_mr = 1'b1;
                  else ph_in = PH_G_CODE;
               end
               PH_G_CODE: begin
                  if (hv) begin
                     fa_in = 16'(hd); fc_in = 2'd1; ph_in = PH_G_A;
                  end else if (b == CH_NL) do_gen = 1'b1;
                  else begin
                     le_in = S_SYNTAX; ph_in = PH_G_SKIP;
                  end
               end
               PH_G_A: begin
                  if (hv) fa_in = {fa_ff[11:0], hd};
                  else if (b == CH_COLON) ph_in = PH_G_BSTART;
                  else if (b == CH_NL) do_gen = 1'b1;
                  else begin
                     le_in = S_SYNTAX; ph_in = PH_G_SKIP;
                  end
               end
               PH_G_BSTART: begin
                  if (hv) begin
                     fb_in = 16'(hd); fc_in = 2'd2; ph_in = PH_G_B;
                  end else begin
                     le_in = S_SYNTAX;
                     if (b == CH_NL) do_gen = 1'b1;
                     else ph_in = PH_G_SKIP;
                  end
               end
               PH_G_B: begin
                  if (hv) fb_in = {fb_ff[11:0], hd};
                  else if (b == CH_COLON) begin
                     fc_in = 2'd3; ph_in = PH_G_SKIP;
                  end else begin
                     le_in = S_SYNTAX;
                     if (b == CH_NL) do_gen = 1'b1;
                     else ph_in = PH_G_SKIP;
                  end
               end
               PH_G_SKIP: begin
                  if (b == CH_NL) do_gen = 1'b1;
                  else ph_in = PH_G_SKIP;
               end
               PH_MR_HEX: begin
                  if (hv) begin
                     fa_in = 16'(hd); ph_in = PH_MR_VAL;
                  end else begin
                     le_in = S_SYNTAX;
                     if (b == CH_NL) do_multi = 1'b1;
                     else ph_in = PH_MR_SKIP;
                  end
               end
               PH_MR_VAL: begin
                  if (hv) fa_in = {fa_ff[11:0], hd};
                  else begin
                     if (int'(vp_ff) < MAX_READS) begin
                        we = 1'b1; vp_in = vp_ff + 1'b1;
                     end
                     do_mr = 1'b1;
                  end
               end
               PH_MR_U: begin
                  le_in = hv ? S_RESPERR : S_SYNTAX;
                  if (b == CH_NL) do_multi = 1'b1;
                  else ph_in = PH_MR_SKIP;
               end
               PH_MR_SKIP: begin
                  if (b == CH_NL) do_multi = 1'b1;
                  else ph_in = PH_MR_SKIP;
               end
               default: ph_in = PH_START;
            endcase
         end
         default: ;
      endcase

      if (do_mr) begin
         if (vp_in >= er_ff) begin
            if (b == CH_NL) do_multi = 1'b1;
            else ph_in = PH_MR_SKIP;
         end else begin
            unique case (b)
               CH_LM: begin
                  le_in = S_NOACK; ph_in = PH_MR_HEX;
               end
               CH_UM: ph_in = PH_MR_HEX;
               CH_UU: ph_in = PH_MR_U;
               CH_NL: do_multi = 1'b1;
               default: begin
                  le_in = S_SYNTAX; ph_in = PH_MR_SKIP;
               end
            endcase
         end
      end

      if (do_gen) begin
         ph_in = PH_START;
         gst = (le_in != 3'd0) ? K_INV : K_DONE;
         unique case (lc_in) inside
            CH_UR: begin exp_req = CH_UR; exp_n = 2'd1; okst = S_ACK; end
            CH_LR: begin exp_req = CH_UR; exp_n = 2'd1; okst = S_NOACK; end
            CH_UW: begin exp_req = CH_UW; okst = S_ACK; end
            CH_LW: begin exp_req = CH_UW; okst = S_NOACK; end
            CH_UV: begin exp_req = CH_UV; exp_n = 2'd3; end
            CH_UI: begin gst = K_INTR; exp_n = 2'd1; end
            CH_UA, CH_UB, CH_US, CH_UC, CH_UF: exp_req = lc_in;
            CH_ZERO: exp_req = CH_NL;
            CH_UD, CH_LF, CH_LI, CH_LU: begin exp_req = lc_in; exp_n = 2'd1; end
            CH_UE, CH_UU: begin gst = K_ERR; exp_n = 2'd1; end
            CH_UM, CH_LM: gst = K_UNEXP;
            default: gst = K_UNREC;
         endcase
         cur = pend_ff ? pc_ff : 8'd0;
         if (gst == K_DONE) begin
            if (cur != exp_req) gst = K_UNEXP;
            else if (fc_in != exp_n) gst = K_INV;
         end else if (gst == K_INTR || gst == K_ERR) begin
            if (fc_in != exp_n) gst = K_INV;
         end
         r_single = 1'b1;
         r.kind = gst;
         if (gst == K_DONE) begin
            pend_in = 1'b0;
            r.status = okst;
            r.ret_form = (fc_in == 2'd0) ? RT_NONE : (fc_in == 2'd1) ? RT_VALUE : RT_CAPS;
            r.value = (fc_in != 2'd0) ? fa_in : 16'd0;
            r.extra_value = (fc_in == 2'd3) ? fb_in : 16'd0;
         end else if (gst == K_INTR || gst == K_ERR) begin
            r.value = fa_in;
         end
      end

      if (do_multi) begin
         ph_in = PH_START;
         if (!(pend_ff && pc_ff == CH_UM)) begin
            r_single = 1'b1; r.kind = K_UNEXP;
         end else begin
            pend_in = 1'b0;
            if (le_in >= S_SYNTAX) begin
               r_single = 1'b1; r.status = le_in; r.value_index = 6'(vp_in);
            end else if (vp_in == '0) begin
               r_single = 1'b1; r.status = le_in; r.ret_form = RT_MULTI;
            end else begin
               r_drain = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0; pc_ff <= '0; er_ff <= '0; ph_ff <= PH_START;
         lc_ff <= '0; fa_ff <= '0; fb_ff <= '0; fc_ff <= '0; le_ff <= '0;
         vp_ff <= '0; idx_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take) begin
            pend_ff <= pend_in; pc_ff <= pc_in; er_ff <= er_in; ph_ff <= ph_in;
            lc_ff <= lc_in; fa_ff <= fa_in; fb_ff <= fb_in; fc_ff <= fc_in;
            le_ff <= le_in; vp_ff <= vp_in; idx_ff <= '0;
         end else if (cmd.emit) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if ((cmd.take && r_single) || cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && we) mem[vp_ff[IDX_W-1:0]] <= fa_ff;
      if (cmd.rd) rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
      if (cmd.take && r_single) rsp_data_ff <= r;
      else if (cmd.emit) begin
         rsp_data_ff.kind        <= K_DONE;
         rsp_data_ff.status      <= le_ff;
         rsp_data_ff.ret_form    <= RT_MULTI;
         rsp_data_ff.value       <= rd_data_ff;
         rsp_data_ff.extra_value <= 16'd0;
         rsp_data_ff.value_index <= 6'(idx_ff);
         rsp_data_ff.last        <= stat.drain_last;
      end
   end

   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.drain      = r_drain;
   assign stat.drain_last = (idx_ff == vp_ff - 1'b1);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule
`default_nettype wire

@@ src/bus_bridge_response_parser.sv @@
// bus bridge response parser: top level
// requests enter on req_ (valid/stall): issue, received byte or timeout tick
// results leave on rsp_ (valid/stall) from an output register; last marks
// the final result caused by one request
// a request that yields one result shows it on rsp_ the cycle after it is
// accepted, and a new request can be accepted every cycle while the output
// register is free or being taken
// a multi-read line ending drains its stored values, each by a value memory
// read and then a load of the output register; requests are held off until
// the drain is done
// when the receiver stalls, the result holds and the request side stalls
// reset clears the pending request and returns the parser to line start;
// stored read values need no clearing
`default_nettype none
module bus_bridge_response_parser
   import bbrp_pkg::*;
#(
   parameter int MAX_READS = 32
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

`include "bus_bridge_response_parser_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   bbrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bbrp_datapath #(.MAX_READS(MAX_READS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `BBRP_ASSERT(a_cmd_excl, $onehot0({cmd.take, cmd.rd, cmd.emit}), "overlapping commands")
   `BBRP_ASSERT_NEXT(a_rd_then_out, cmd.rd, req_stall, "request accepted during drain")
   `BBRP_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_valid, "drained value not presented")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the bus bridge response parser: line-level stimulus, predicted results
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import bbrp_pkg::*;

   localparam int MAX_READS = 32;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   bus_bridge_response_parser #(.MAX_READS(MAX_READS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   req_type request_queue[$];
   rsp_type expected_results[$];
   int error_count = 0;
   int result_count = 0;
   int request_count = 0;
   int multi_lines = 0;
   bit quiet_phase = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int watchdog = 0;

   // parser model state
   logic        m_pending;
   logic [7:0]  m_pend_code;
   logic [5:0]  m_exp_reads;
   phase_type   m_phase;
   logic [7:0]  m_line_code;
   logic [15:0] m_field_a;
   logic [15:0] m_field_b;
   logic [1:0]  m_nfields;
   logic [2:0]  m_line_err;
   logic [15:0] m_values[MAX_READS];
   logic [5:0]  m_nvalues;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int hex_digit(input logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return -1;
   endfunction

   task automatic push_result(input logic [2:0] k, input logic [2:0] s, input logic [1:0] rt,
                              input logic [15:0] v, input logic [15:0] x,
                              input logic [5:0] idx);
      rsp_type r;
      r.kind = k; r.status = s; r.ret_form = rt; r.value = v;
      r.extra_value = x; r.value_index = idx; r.last = 1'b0;
      expected_results = {expected_results, r};
   endtask

   task automatic close_general();
      logic [2:0] k;
      logic [2:0] okst;
      int exp_code;
      int exp_n;
      int cur;
      k = (m_line_err != 0) ? K_INV : K_DONE;
      okst = S_OK;
      exp_code = -1;
      exp_n = 0;
      m_phase = PH_START;
      case (m_line_code) inside
         CH_UR: begin exp_code = CH_UR; exp_n = 1; okst = S_ACK; end
         CH_LR: begin exp_code = CH_UR; exp_n = 1; okst = S_NOACK; end
         CH_UW: begin exp_code = CH_UW; okst = S_ACK; end
         CH_LW: begin exp_code = CH_UW; okst = S_NOACK; end
         CH_UV: begin exp_code = CH_UV; exp_n = 3; end
         CH_UI: begin k = K_INTR; exp_n = 1; end
         CH_UA, CH_UB, CH_US, CH_UC, CH_UF: exp_code = m_line_code;
         CH_ZERO: exp_code = CH_NL;
         CH_UD, CH_LF, CH_LI, CH_LU: begin exp_code = m_line_code; exp_n = 1; end
         CH_UE, CH_UU: begin k = K_ERR; exp_n = 1; end
         CH_UM, CH_LM: k = K_UNEXP;
         default: k = K_UNREC;
      endcase
      if (k == K_DONE) begin
         cur = m_pending ? int'(m_pend_code) : 0;
         if (cur != exp_code) k = K_UNEXP;
         else if (m_nfields != exp_n) k = K_INV;
      end else if (k == K_INTR || k == K_ERR) begin
         if (m_nfields != exp_n) k = K_INV;
      end
      if (k == K_DONE) begin
         m_pending = 1'b0;
         push_result(K_DONE, okst,
                     (m_nfields == 0) ? RT_NONE : (m_nfields == 1) ? RT_VALUE : RT_CAPS,
                     (m_nfields != 0) ? m_field_a : 16'd0,
                     (m_nfields == 3) ? m_field_b : 16'd0, '0);
      end else if (k == K_INTR || k == K_ERR) begin
         push_result(k, S_OK, RT_NONE, m_field_a, '0, '0);
      end else begin
         push_result(k, S_OK, RT_NONE, '0, '0, '0);
      end
   endtask

   task automatic close_multi();
      m_phase = PH_START;
      multi_lines++;
      if (!(m_pending && m_pend_code == CH_UM)) begin
         push_result(K_UNEXP, S_OK, RT_NONE, '0, '0, '0);
      end else begin
         m_pending = 1'b0;
         if (m_line_err >= S_SYNTAX)
            push_result(K_DONE, m_line_err, RT_NONE, '0, '0, m_nvalues);
         else if (m_nvalues == 0)
            push_result(K_DONE, m_line_err, RT_MULTI, '0, '0, '0);
         else
            for (int i = 0; i < m_nvalues; i++)
               push_result(K_DONE, m_line_err, RT_MULTI, m_values[5'(i)], '0, 6'(i));
      end
   endtask

   task automatic skip_or_close(input logic [7:0] b, input bit multi);
      if (b == CH_NL) begin
         if (multi) close_multi();
         else close_general();
      end else begin
         m_phase = multi ? PH_MR_SKIP : PH_G_SKIP;
      end
   endtask

   task automatic multi_element(input logic [7:0] b);
      if (m_nvalues >= m_exp_reads) begin
         skip_or_close(b, 1'b1);
      end else begin
         case (b)
            CH_LM: begin m_line_err = S_NOACK; m_phase = PH_MR_HEX; end
            CH_UM: m_phase = PH_MR_HEX;
            CH_UU: m_phase = PH_MR_U;
            CH_NL: close_multi();
            default: begin m_line_err = S_SYNTAX; m_phase = PH_MR_SKIP; end
         endcase
      end
   endtask

   task automatic parse_byte(input logic [7:0] b);
      int d;
      d = hex_digit(b);
      case (m_phase)
         PH_START: begin
            m_line_code = b; m_field_a = '0; m_field_b = '0;
            m_nfields = '0; m_line_err = '0; m_nvalues = '0;
            if (b == CH_NL) close_general();
            else if ((b == CH_UM || b == CH_LM) && m_pending && m_pend_code == CH_UM)
               multi_element(b);
            else m_phase = PH_G_CODE;
         end
         PH_G_CODE: begin
            if (d >= 0) begin
               m_field_a = 16'(d); m_nfields = 2'd1; m_phase = PH_G_A;
            end else if (b == CH_NL) close_general();
            else begin m_line_err = S_SYNTAX; m_phase = PH_G_SKIP; end
         end
         PH_G_A: begin
            if (d >= 0) m_field_a = {m_field_a[11:0], 4'(d)};
            else if (b == CH_COLON) m_phase = PH_G_BSTART;
            else if (b == CH_NL) close_general();
            else begin m_line_err = S_SYNTAX; m_phase = PH_G_SKIP; end
         end
         PH_G_BSTART: begin
            if (d >= 0) begin
               m_field_b = 16'(d); m_nfields = 2'd2; m_phase = PH_G_B;
            end else begin
               m_line_err = S_SYNTAX; skip_or_close(b, 1'b0);
            end
         end
         PH_G_B: begin
            if (d >= 0) m_field_b = {m_field_b[11:0], 4'(d)};
            else if (b == CH_COLON) begin m_nfields = 2'd3; m_phase = PH_G_SKIP; end
            else begin m_line_err = S_SYNTAX; skip_or_close(b, 1'b0); end
         end
         PH_G_SKIP: skip_or_close(b, 1'b0);
         PH_MR_HEX: begin
            if (d >= 0) begin m_field_a = 16'(d); m_phase = PH_MR_VAL; end
            else begin m_line_err = S_SYNTAX; skip_or_close(b, 1'b1); end
         end
         PH_MR_VAL: begin
            if (d >= 0) m_field_a = {m_field_a[11:0], 4'(d)};
            else begin
               if (m_nvalues < MAX_READS) begin
                  m_values[m_nvalues[4:0]] = m_field_a;
                  m_nvalues++;
               end
               multi_element(b);
            end
         end
         PH_MR_U: begin
            m_line_err = (d >= 0) ? S_RESPERR : S_SYNTAX;
            skip_or_close(b, 1'b1);
         end
         PH_MR_SKIP: skip_or_close(b, 1'b1);
         default: m_phase = PH_START;
      endcase
   endtask

   task automatic predict_request(input req_type r);
      int before_n;
      before_n = expected_results.size();
      case (r.opcode)
         OP_ISSUE: begin
            if (m_pending) push_result(K_BUSY, S_OK, RT_NONE, '0, '0, '0);
            else if (r.request_code == CH_UT) push_result(K_DONE, S_OK, RT_NONE, '0, '0, '0);
            else begin
               m_pending = 1'b1;
               m_pend_code = r.request_code;
               m_exp_reads = (r.read_count > MAX_READS) ? 6'(MAX_READS) : r.read_count;
            end
         end
         OP_RX: parse_byte(r.rx_byte);
         OP_TIMEOUT: begin
            if (m_pending) begin
               m_pending = 1'b0;
               push_result(K_DONE, S_TIMEOUT, RT_NONE, '0, '0, '0);
            end
         end
         default: ;
      endcase
      if (expected_results.size() > before_n)
         expected_results[$].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input rsp_type got, input rsp_type want);
      error_count++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // stimulus helpers
   task automatic add_raw(input logic [1:0] op, input logic [7:0] code, input logic [5:0] cnt,
                          input logic [7:0] b);
      req_type r;
      r.opcode = op; r.request_code = code; r.read_count = cnt; r.rx_byte = b;
      request_queue = {request_queue, r};
   endtask

   task automatic add_issue(input logic [7:0] code, input logic [5:0] cnt);
      add_raw(OP_ISSUE, code, cnt, 8'($urandom));
   endtask

   task automatic add_byte(input logic [7:0] b);
      add_raw(OP_RX, 8'($urandom), 6'($urandom), b);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic string rand_hex(input int maxlen);
      string s;
      string digits;
      int n;
      digits = "0123456789abcdefABCDEF";
      s = "";
      n = $urandom_range(1, maxlen);
      for (int i = 0; i < n; i++) s = {s, string'(digits[$urandom_range(0, 21)])};
      return s;
   endfunction

   task automatic add_random_sequence();
      int pick;
      int n;
      string s;
      string codes;
      codes = "RrWwVIABSCF0DfiuEUMmXZ";
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         // multi-read request and line
         n = $urandom_range(0, 6);
         if ($urandom_range(0, 15) == 0) n = $urandom_range(30, 63);
         add_issue(CH_UM, 6'(n));
         s = "";
         for (int i = 0; i < n + $urandom_range(0, 1); i++) begin
            case ($urandom_range(0, 19))
               0: s = {s, "U", rand_hex(3)};
               1: s = {s, "M"};
               2: s = {s, "x"};
               3: s = {s, "m", rand_hex(5)};
               default: s = {s, "M", rand_hex(4)};
            endcase
         end
         add_text({s, "\n"});
      end else if (pick < 8) begin
         // general request and matching-ish line
         s = "";
         s = {s, string'(codes[$urandom_range(0, codes.len() - 1)])};
         if (s == "0") add_issue(CH_NL, 6'($urandom));
         else if (s == "r" || s == "w") add_issue(s[0] - 8'h20, 6'($urandom));
         else if ($urandom_range(0, 3) != 0) add_issue(s[0], 6'($urandom));
         case ($urandom_range(0, 5))
            0: ;
            1, 2: s = {s, rand_hex(6)};
            3: s = {s, rand_hex(4), ":", rand_hex(4), ":", rand_hex(3)};
            4: s = {s, rand_hex(4), ":", rand_hex(4)};
            default: s = {s, rand_hex(2), string'(codes[$urandom_range(0, 5)])};
         endcase
         add_text({s, "\n"});
         if ($urandom_range(0, 3) == 0) add_raw(OP_TIMEOUT, 8'($urandom), 6'($urandom), 8'($urandom));
      end else begin
         // noise
         case ($urandom_range(0, 3))
            0: add_byte(8'($urandom));
            1: add_raw(OP_TIMEOUT, 8'($urandom), 6'($urandom), 8'($urandom));
            2: add_issue(8'($urandom), 6'($urandom));
            default: add_raw(2'd3, 8'($urandom), 6'($urandom), 8'($urandom));
         endcase
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) request_count++;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            req_type r;
            r = request_queue[0];
            request_queue.delete(0);
            predict_request(r);
            req_data <= r;
            req_valid <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_type want;
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_data, '0);
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_data.kind !== want.kind) report_mismatch("kind", rsp_data, want);
               else if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data, want);
               else if (rsp_data.ret_form !== want.ret_form)
                  report_mismatch("return form", rsp_data, want);
               else if (rsp_data.value !== want.value) report_mismatch("value", rsp_data, want);
               else if (rsp_data.extra_value !== want.extra_value)
                  report_mismatch("extra_value", rsp_data, want);
               else if (rsp_data.value_index !== want.value_index)
                  report_mismatch("value_index", rsp_data, want);
               else if (rsp_data.last !== want.last) report_mismatch("last", rsp_data, want);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      m_pending = 1'b0; m_pend_code = '0; m_exp_reads = '0; m_phase = PH_START;
      m_line_code = '0; m_field_a = '0; m_field_b = '0; m_nfields = '0;
      m_line_err = '0; m_nvalues = '0;

      // directed part
      add_issue(CH_UT, 6'd0);
      add_issue(CH_UR, 6'd0);
      add_issue(CH_UW, 6'd0);
      add_text("R12345\n");
      add_issue(CH_UV, 6'd0);
      add_text("V1:ffff:zz\n");
      add_text("I7\n\n");
      add_raw(OP_TIMEOUT, 8'hFF, 6'h3F, 8'hFF);
      add_raw(OP_TIMEOUT, 8'h00, 6'h00, 8'h00);
      add_issue(CH_UM, 6'h3F);
      add_text("M0mFFFF\n");
      add_issue(CH_UM, 6'd2);
      add_text("MU5\n");
      add_raw(2'd3, 8'hFF, 6'h3F, 8'hFF);
      add_byte(8'hFF);
      add_byte(CH_NL);
      while (request_queue.size() < 290) add_random_sequence();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() > 60) @(posedge clock);
      quiet_phase = 1'b1;
      while (request_queue.size() > 0 || req_valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("%0d requests accepted, %0d results checked, %0d multi-read lines",
               request_count, result_count, multi_lines);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ bus_bridge_response_parser.f @@
+incdir+src
src/bbrp_pkg.sv
src/bbrp_ctrl.sv
src/bbrp_datapath.sv
src/bus_bridge_response_parser.sv
tb/tb_top.sv
